// ===== rtl/core/bpc_pkg.sv =====
// Package for the barometric pressure compensation block.
// Holds field widths, range limits, register indexes and the word types
// passed between the pipeline segments. No dependencies.
`default_nettype none

package bpc_pkg;

  localparam int RAW_W   = 24;
  localparam int COEF_W  = 16;
  localparam int IDX_W   = 3;
  localparam int TEMP_W  = 15;
  localparam int PRESS_W = 17;

  localparam int DT_W   = 25;
  localparam int MUL_W  = 42;
  localparam int SQ_W   = 50;
  localparam int T1_W   = 19;
  localparam int T2_W   = 17;
  localparam int AC_W   = 40;
  localparam int SQT_W  = 35;
  localparam int TC_W   = 21;
  localparam int PROD_W = 64;
  localparam int X_W    = 44;
  localparam int P_W    = 29;

  localparam int T_REF     = 2000;
  localparam int T_LOW     = -1500;
  localparam int TEMP_MIN  = -4000;
  localparam int TEMP_MAX  = 8500;
  localparam int PRESS_MIN = 1000;
  localparam int PRESS_MAX = 120000;

  typedef enum logic [IDX_W-1:0] {
    CFG_SENS     = 3'd0,
    CFG_OFF      = 3'd1,
    CFG_TCS      = 3'd2,
    CFG_TCO      = 3'd3,
    CFG_TREF     = 3'd4,
    CFG_TEMPSENS = 3'd5
  } cfg_idx_t;

  typedef struct packed {
    logic [COEF_W-1:0] sens;
    logic [COEF_W-1:0] off;
    logic [COEF_W-1:0] tcs;
    logic [COEF_W-1:0] tco;
    logic [COEF_W-1:0] tref;
    logic [COEF_W-1:0] tempsens;
  } cfg_t;

  typedef struct packed {
    logic [RAW_W-1:0] raw_pressure;
    logic [RAW_W-1:0] raw_temp;
  } raw_t;

  typedef struct packed {
    logic [RAW_W-1:0]       d1;
    logic signed [T1_W-1:0] temp1;
    logic [T2_W-1:0]        t2;
    logic signed [AC_W-1:0] off1;
    logic signed [AC_W-1:0] sens1;
  } front_t;

  typedef struct packed {
    logic [RAW_W-1:0]       d1;
    logic signed [TC_W-1:0] temp;
    logic signed [AC_W-1:0] off;
    logic signed [AC_W-1:0] sens;
  } corr_t;

  typedef struct packed {
    logic signed [TEMP_W-1:0] temp_centi;
    logic [PRESS_W-1:0]       press_centi;
    logic                     clipped;
  } res_t;

endpackage

`default_nettype wire

// ===== rtl/core/bpc_if.sv =====
// Valid/ready channel interfaces for raw input words and result words.
// Depends on bpc_pkg for field widths.
`default_nettype none

interface bpc_in_if import bpc_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [RAW_W-1:0] raw_pressure;
  logic [RAW_W-1:0] raw_temp;

  modport source (output valid, output raw_pressure, output raw_temp, input ready);
  modport sink (input valid, input raw_pressure, input raw_temp, output ready);
endinterface

interface bpc_out_if import bpc_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic signed [TEMP_W-1:0] temp_centi;
  logic [PRESS_W-1:0]       press_centi;
  logic                     clipped;

  modport source (output valid, output temp_centi, output press_centi, output clipped,
                  input ready);
  modport sink (input valid, input temp_centi, input press_centi, input clipped,
                output ready);
endinterface

`default_nettype wire

// ===== rtl/core/barometric_pressure_compensation_top.sv =====
// Barometric pressure compensation, second-order scheme, nine-stage pipeline.
// Throughput: one word per cycle while out_ch.ready is high; each stage holds
// its word while the one after it is full and stalled, so bubbles close up and
// nothing is dropped. Reset (synchronous, rst_n low) empties every stage and
// clears all six calibration registers to zero. Depends on bpc_pkg, bpc_if and
// the segments.
`default_nettype none

module barometric_pressure_compensation_top import bpc_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst_n,
  bpc_in_if.sink                 in_ch,
  bpc_out_if.source              out_ch,
  input  wire logic              cfg_we,
  input  wire logic [IDX_W-1:0]  cfg_index,
  input  wire logic [COEF_W-1:0] cfg_wdata
);

  cfg_t   cfg_r;
  raw_t   raw_word;
  front_t fr_word;
  corr_t  co_word;
  res_t   res_word;
  logic   fr_valid;
  logic   fr_ready;
  logic   co_valid;
  logic   co_ready;
  logic   in_rdy;
  logic   res_valid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_SENS:     cfg_r.sens     <= cfg_wdata;
        CFG_OFF:      cfg_r.off      <= cfg_wdata;
        CFG_TCS:      cfg_r.tcs      <= cfg_wdata;
        CFG_TCO:      cfg_r.tco      <= cfg_wdata;
        CFG_TREF:     cfg_r.tref     <= cfg_wdata;
        CFG_TEMPSENS: cfg_r.tempsens <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign raw_word.raw_pressure = in_ch.raw_pressure;
  assign raw_word.raw_temp     = in_ch.raw_temp;
  assign in_ch.ready           = in_rdy;

  bpc_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .in_valid  (in_ch.valid),
    .in_ready  (in_rdy),
    .in_word   (raw_word),
    .out_valid (fr_valid),
    .out_ready (fr_ready),
    .out_word  (fr_word)
  );

  bpc_corr u_corr (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (fr_valid),
    .in_ready  (fr_ready),
    .in_word   (fr_word),
    .out_valid (co_valid),
    .out_ready (co_ready),
    .out_word  (co_word)
  );

  bpc_press u_press (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (co_valid),
    .in_ready  (co_ready),
    .in_word   (co_word),
    .out_valid (res_valid),
    .out_ready (out_ch.ready),
    .out_word  (res_word)
  );

  assign out_ch.valid       = res_valid;
  assign out_ch.temp_centi  = res_word.temp_centi;
  assign out_ch.press_centi = res_word.press_centi;
  assign out_ch.clipped     = res_word.clipped;

  a_res_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> (out_ch.temp_centi >= TEMP_MIN) && (out_ch.temp_centi <= TEMP_MAX)
                  && (out_ch.press_centi >= PRESS_MIN) && (out_ch.press_centi <= PRESS_MAX))
    else $error("result outside saturation range");

  a_clip_at_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.clipped |-> (out_ch.temp_centi == TEMP_MIN)
      || (out_ch.temp_centi == TEMP_MAX) || (out_ch.press_centi == PRESS_MIN)
      || (out_ch.press_centi == PRESS_MAX))
    else $error("clipped flag set with no result at a bound");

  a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ch.ready |-> out_ch.valid && !out_ch.ready)
    else $error("input stalled while the output side moves");

  a_reset_empties: assert property (@(posedge clk)
    !rst_n |=> !out_ch.valid)
    else $error("result word present after reset");

endmodule

`default_nettype wire

// ===== rtl/core/bpc_front.sv =====
// Front pipeline segment: temperature delta, coefficient products and
// first-order temperature, offset and sensitivity. Depends on bpc_pkg.
`default_nettype none

module bpc_front import bpc_pkg::*; (
  input  wire logic   clk,
  input  wire logic   rst_n,
  input  wire cfg_t   cfg,
  input  wire logic   in_valid,
  output logic        in_ready,
  input  wire raw_t   in_word,
  output logic        out_valid,
  input  wire logic   out_ready,
  output front_t      out_word
);

  localparam int NST = 3;

  logic [NST-1:0] v_r;
  logic [NST-1:0] adv;

  logic [RAW_W-1:0]       d1_a_r;
  logic signed [DT_W-1:0] dt_a_r;

  logic [RAW_W-1:0]        d1_b_r;
  logic signed [MUL_W-1:0] mt_b_r;
  logic signed [MUL_W-1:0] mtco_b_r;
  logic signed [MUL_W-1:0] mtcs_b_r;
  logic signed [SQ_W-1:0]  sq_b_r;

  logic signed [MUL_W-1:0] mt_adj;
  logic signed [MUL_W-1:0] mtco_adj;
  logic signed [MUL_W-1:0] mtcs_adj;
  logic signed [T1_W-1:0]  tq;
  logic signed [34:0]      off_div;
  logic signed [33:0]      sens_div;
  front_t                  c_nxt;
  front_t                  c_r;

  always_comb begin
    adv[NST-1] = !v_r[NST-1] || out_ready;
    for (int i = NST - 2; i >= 0; i--) begin
      adv[i] = !v_r[i] || adv[i+1];
    end
  end

  assign in_ready  = adv[0];
  assign out_valid = v_r[NST-1];
  assign out_word  = c_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (adv[0]) begin
        v_r[0] <= in_valid;
      end
      for (int i = 1; i < NST; i++) begin
        if (adv[i]) begin
          v_r[i] <= v_r[i-1];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv[0]) begin
      d1_a_r <= in_word.raw_pressure;
      dt_a_r <= $signed({1'b0, in_word.raw_temp}) - $signed({1'b0, cfg.tref, 8'd0});
    end
    if (adv[1]) begin
      d1_b_r   <= d1_a_r;
      mt_b_r   <= dt_a_r * $signed({1'b0, cfg.tempsens});
      mtco_b_r <= dt_a_r * $signed({1'b0, cfg.tco});
      mtcs_b_r <= dt_a_r * $signed({1'b0, cfg.tcs});
      sq_b_r   <= dt_a_r * dt_a_r;
    end
    if (adv[2]) begin
      c_r <= c_nxt;
    end
  end

  always_comb begin
    mt_adj   = mt_b_r + (mt_b_r[MUL_W-1] ? 42'sd8388607 : 42'sd0);
    mtco_adj = mtco_b_r + (mtco_b_r[MUL_W-1] ? 42'sd127 : 42'sd0);
    mtcs_adj = mtcs_b_r + (mtcs_b_r[MUL_W-1] ? 42'sd255 : 42'sd0);
    tq       = mt_adj[MUL_W-1:23];
    off_div  = mtco_adj[MUL_W-1:7];
    sens_div = mtcs_adj[MUL_W-1:8];

    c_nxt.d1    = d1_b_r;
    c_nxt.temp1 = tq + T1_W'(T_REF);
    c_nxt.t2    = sq_b_r[47:31];
    c_nxt.off1  = $signed({8'd0, cfg.off, 16'd0}) + {{5{off_div[34]}}, off_div};
    c_nxt.sens1 = $signed({9'd0, cfg.sens, 15'd0}) + {{6{sens_div[33]}}, sens_div};
  end

endmodule

`default_nettype wire

// ===== rtl/core/bpc_corr.sv =====
// Second-order correction segment: squares of the cold deltas, offset and
// sensitivity corrections, corrected temperature. Depends on bpc_pkg.
`default_nettype none

module bpc_corr import bpc_pkg::*; (
  input  wire logic   clk,
  input  wire logic   rst_n,
  input  wire logic   in_valid,
  output logic        in_ready,
  input  wire front_t in_word,
  output logic        out_valid,
  input  wire logic   out_ready,
  output corr_t       out_word
);

  localparam int NST = 2;

  logic [NST-1:0] v_r;
  logic [NST-1:0] adv;

  front_t             fr_d_r;
  logic [SQT_W-1:0]   aa_d_r;
  logic [SQT_W-1:0]   bb_d_r;
  logic               lt_d_r;
  logic               ltm_d_r;

  logic signed [T1_W-1:0]   a_dt;
  logic signed [T1_W-1:0]   b_dt;
  logic signed [2*T1_W-1:0] a_sq;
  logic signed [2*T1_W-1:0] b_sq;

  logic [AC_W-1:0] aa5;
  logic [AC_W-1:0] bb7;
  logic [AC_W-1:0] bb11;
  logic [AC_W-1:0] off2;
  logic [AC_W-1:0] sens2;
  corr_t           e_nxt;
  corr_t           e_r;

  always_comb begin
    adv[NST-1] = !v_r[NST-1] || out_ready;
    for (int i = NST - 2; i >= 0; i--) begin
      adv[i] = !v_r[i] || adv[i+1];
    end
  end

  assign in_ready  = adv[0];
  assign out_valid = v_r[NST-1];
  assign out_word  = e_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (adv[0]) begin
        v_r[0] <= in_valid;
      end
      for (int i = 1; i < NST; i++) begin
        if (adv[i]) begin
          v_r[i] <= v_r[i-1];
        end
      end
    end
  end

  always_comb begin
    a_dt = in_word.temp1 - T1_W'(T_REF);
    b_dt = in_word.temp1 - T1_W'(T_LOW);
    a_sq = a_dt * a_dt;
    b_sq = b_dt * b_dt;
  end

  always_ff @(posedge clk) begin
    if (adv[0]) begin
      fr_d_r  <= in_word;
      aa_d_r  <= a_sq[SQT_W-1:0];
      bb_d_r  <= b_sq[SQT_W-1:0];
      lt_d_r  <= in_word.temp1 < T1_W'(T_REF);
      ltm_d_r <= in_word.temp1 < T1_W'(T_LOW);
    end
    if (adv[1]) begin
      e_r <= e_nxt;
    end
  end

  always_comb begin
    aa5   = {5'd0, aa_d_r} + {3'd0, aa_d_r, 2'd0};
    bb7   = {2'd0, bb_d_r, 3'd0} - {5'd0, bb_d_r};
    bb11  = {2'd0, bb_d_r, 3'd0} + {4'd0, bb_d_r, 1'b0} + {5'd0, bb_d_r};
    off2  = (lt_d_r ? (aa5 >> 1) : '0) + (ltm_d_r ? bb7 : '0);
    sens2 = (lt_d_r ? (aa5 >> 2) : '0) + (ltm_d_r ? (bb11 >> 1) : '0);

    e_nxt.d1   = fr_d_r.d1;
    e_nxt.temp = {{(TC_W-T1_W){fr_d_r.temp1[T1_W-1]}}, fr_d_r.temp1}
               - (lt_d_r ? {{(TC_W-T2_W){1'b0}}, fr_d_r.t2} : {TC_W{1'b0}});
    e_nxt.off  = fr_d_r.off1 - $signed(off2);
    e_nxt.sens = fr_d_r.sens1 - $signed(sens2);
  end

endmodule

`default_nettype wire

// ===== rtl/core/bpc_press.sv =====
// Pressure segment: split raw-pressure by sensitivity product, scaling,
// offset removal and saturation of both results. Depends on bpc_pkg.
`default_nettype none

module bpc_press import bpc_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  in_valid,
  output logic       in_ready,
  input  wire corr_t in_word,
  output logic       out_valid,
  input  wire logic  out_ready,
  output res_t       out_word
);

  localparam int NST = 4;
  localparam logic signed [TC_W-1:0] T_LO = TC_W'(TEMP_MIN);
  localparam logic signed [TC_W-1:0] T_HI = TC_W'(TEMP_MAX);
  localparam logic signed [P_W-1:0]  P_LO = P_W'(PRESS_MIN);
  localparam logic signed [P_W-1:0]  P_HI = P_W'(PRESS_MAX);

  logic [NST-1:0] v_r;
  logic [NST-1:0] adv;

  logic signed [19:0] sens_hi;
  logic [43:0]        plo_f_r;
  logic signed [44:0] phi_f_r;
  logic signed [AC_W-1:0] off_f_r;
  logic [TEMP_W-1:0]  tsat_f_r;
  logic               tclip_f_r;
  logic [TEMP_W-1:0]  tsat_nxt;
  logic               tclip_nxt;

  logic signed [PROD_W-1:0] prod_g_r;
  logic signed [AC_W-1:0]   off_g_r;
  logic [TEMP_W-1:0]        tsat_g_r;
  logic                     tclip_g_r;

  logic signed [PROD_W-1:0] prod_adj;
  logic signed [42:0]       pq;
  logic signed [X_W-1:0]    x_h_r;
  logic [TEMP_W-1:0]        tsat_h_r;
  logic                     tclip_h_r;

  logic signed [X_W-1:0] x_adj;
  logic signed [P_W-1:0] p;
  res_t                  res_nxt;
  res_t                  res_r;

  always_comb begin
    adv[NST-1] = !v_r[NST-1] || out_ready;
    for (int i = NST - 2; i >= 0; i--) begin
      adv[i] = !v_r[i] || adv[i+1];
    end
  end

  assign in_ready  = adv[0];
  assign out_valid = v_r[NST-1];
  assign out_word  = res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (adv[0]) begin
        v_r[0] <= in_valid;
      end
      for (int i = 1; i < NST; i++) begin
        if (adv[i]) begin
          v_r[i] <= v_r[i-1];
        end
      end
    end
  end

  always_comb begin
    sens_hi   = in_word.sens[AC_W-1:20];
    tsat_nxt  = in_word.temp[TEMP_W-1:0];
    tclip_nxt = 1'b0;
    if (in_word.temp < T_LO) begin
      tsat_nxt  = T_LO[TEMP_W-1:0];
      tclip_nxt = 1'b1;
    end else if (in_word.temp > T_HI) begin
      tsat_nxt  = T_HI[TEMP_W-1:0];
      tclip_nxt = 1'b1;
    end
  end

  always_comb begin
    prod_adj = prod_g_r + (prod_g_r[PROD_W-1] ? 64'sd2097151 : 64'sd0);
    pq       = prod_adj[PROD_W-1:21];
    x_adj    = x_h_r + (x_h_r[X_W-1] ? 44'sd32767 : 44'sd0);
    p        = x_adj[X_W-1:15];

    res_nxt.temp_centi  = tsat_h_r;
    res_nxt.press_centi = p[PRESS_W-1:0];
    res_nxt.clipped     = tclip_h_r;
    if (p < P_LO) begin
      res_nxt.press_centi = P_LO[PRESS_W-1:0];
      res_nxt.clipped     = 1'b1;
    end else if (p > P_HI) begin
      res_nxt.press_centi = P_HI[PRESS_W-1:0];
      res_nxt.clipped     = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (adv[0]) begin
      plo_f_r   <= in_word.d1 * in_word.sens[19:0];
      phi_f_r   <= $signed({1'b0, in_word.d1}) * sens_hi;
      off_f_r   <= in_word.off;
      tsat_f_r  <= tsat_nxt;
      tclip_f_r <= tclip_nxt;
    end
    if (adv[1]) begin
      prod_g_r  <= {phi_f_r[43:0], 20'd0} + {20'd0, plo_f_r};
      off_g_r   <= off_f_r;
      tsat_g_r  <= tsat_f_r;
      tclip_g_r <= tclip_f_r;
    end
    if (adv[2]) begin
      x_h_r     <= {pq[42], pq} - {{(X_W-AC_W){off_g_r[AC_W-1]}}, off_g_r};
      tsat_h_r  <= tsat_g_r;
      tclip_h_r <= tclip_g_r;
    end
    if (adv[3]) begin
      res_r <= res_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== dv/bpc_compensation_checker.sv =====
// Checker for the barometric pressure compensation block: tracks calibration writes,
// predicts each compensated reading from accepted raw words and compares result words.
// Depends on bpc_pkg for widths, limits, register indexes and the result word type.
module bpc_compensation_checker import bpc_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     cfg_we,
  input  logic [IDX_W-1:0]         cfg_index,
  input  logic [COEF_W-1:0]        cfg_wdata,
  input  logic                     in_valid,
  input  logic                     in_ready,
  input  logic [RAW_W-1:0]         in_raw_pressure,
  input  logic [RAW_W-1:0]         in_raw_temp,
  input  logic                     out_valid,
  input  logic                     out_ready,
  input  logic signed [TEMP_W-1:0] out_temp_centi,
  input  logic [PRESS_W-1:0]       out_press_centi,
  input  logic                     out_clipped,
  output int                       pending,
  output int                       err_count,
  output int                       words_checked,
  output int                       clip_count
);

  localparam longint DT_SQ_DIV = 64'sd2147483648;

  cfg_t cal;
  res_t expected_readings[$];

  function automatic res_t compensate(input cfg_t c, input logic [RAW_W-1:0] d1_raw,
                                      input logic [RAW_W-1:0] d2_raw);
    longint d1, d2, dt, temp, t2, off2, sens2, off, sens, p, a, b;
    longint k_sens, k_off, k_tcs, k_tco, k_tref, k_tsens;
    logic clip;
    res_t r;
    d1 = d1_raw;
    d2 = d2_raw;
    k_sens = c.sens;
    k_off = c.off;
    k_tcs = c.tcs;
    k_tco = c.tco;
    k_tref = c.tref;
    k_tsens = c.tempsens;
    t2 = 0;
    off2 = 0;
    sens2 = 0;
    clip = 1'b0;

    dt = d2 - k_tref * 256;
    temp = T_REF + (dt * k_tsens) / 8388608;
    if (temp < T_REF) begin
      a = temp - T_REF;
      t2 = (dt * dt) / DT_SQ_DIV;
      off2 = 5 * (a * a) / 2;
      sens2 = 5 * (a * a) / 4;
    end
    if (temp < T_LOW) begin
      b = temp - T_LOW;
      off2 = off2 + 7 * (b * b);
      sens2 = sens2 + 11 * (b * b) / 2;
    end
    temp = temp - t2;

    off = k_off * 65536 + (k_tco * dt) / 128;
    sens = k_sens * 32768 + (k_tcs * dt) / 256;
    off = off - off2;
    sens = sens - sens2;
    p = ((d1 * sens) / 2097152 - off) / 32768;

    if (temp < TEMP_MIN) begin
      temp = TEMP_MIN;
      clip = 1'b1;
    end
    if (temp > TEMP_MAX) begin
      temp = TEMP_MAX;
      clip = 1'b1;
    end
    if (p < PRESS_MIN) begin
      p = PRESS_MIN;
      clip = 1'b1;
    end
    if (p > PRESS_MAX) begin
      p = PRESS_MAX;
      clip = 1'b1;
    end

    r.temp_centi = temp[TEMP_W-1:0];
    r.press_centi = p[PRESS_W-1:0];
    r.clipped = clip;
    return r;
  endfunction

  always @(posedge clk) begin
    res_t want;
    if (!rst_n) begin
      cal = '0;
      expected_readings.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (expected_readings.size() == 0) begin
          err_count++;
          $error("unexpected result word: temp_centi %0d press_centi %0d clipped %0d",
                 out_temp_centi, out_press_centi, out_clipped);
        end else begin
          want = expected_readings.pop_front();
          words_checked++;
          if (want.clipped) clip_count++;
          if (out_temp_centi !== want.temp_centi) begin
            err_count++;
            $error("temp_centi: expected %0d, got %0d", want.temp_centi, out_temp_centi);
          end
          if (out_press_centi !== want.press_centi) begin
            err_count++;
            $error("press_centi: expected %0d, got %0d", want.press_centi, out_press_centi);
          end
          if (out_clipped !== want.clipped) begin
            err_count++;
            $error("clipped: expected %0d, got %0d", want.clipped, out_clipped);
          end
        end
      end
      if (in_valid && in_ready)
        expected_readings.push_back(compensate(cal, in_raw_pressure, in_raw_temp));
      if (cfg_we) begin
        case (cfg_index)
          CFG_SENS: begin
            cal.sens = cfg_wdata;
          end
          CFG_OFF: begin
            cal.off = cfg_wdata;
          end
          CFG_TCS: begin
            cal.tcs = cfg_wdata;
          end
          CFG_TCO: begin
            cal.tco = cfg_wdata;
          end
          CFG_TREF: begin
            cal.tref = cfg_wdata;
          end
          CFG_TEMPSENS: begin
            cal.tempsens = cfg_wdata;
          end
          default: begin
          end
        endcase
      end
    end
    pending = expected_readings.size();
  end

endmodule

// ===== dv/tb_barometric_pressure_compensation_top.sv =====
// Testbench top for barometric_pressure_compensation_top: clock, reset, calibration
// writes, raw word stimulus with idling and stalls, and the verdict.
// Depends on bpc_pkg, bpc_if, the block and bpc_compensation_checker.
module tb_barometric_pressure_compensation_top;
  import bpc_pkg::*;

  localparam logic [IDX_W-1:0] CFG_SPARE_LO = 3'd6;
  localparam logic [IDX_W-1:0] CFG_SPARE_HI = 3'd7;
  localparam int CYCLE_LIMIT = 400000;
  localparam int RAW_MAX = 16777215;
  localparam int RANDOM_PHASES = 8;
  localparam int WORDS_PER_PHASE = 250;

  localparam logic [COEF_W-1:0] TYP_SENS = 16'd40127;
  localparam logic [COEF_W-1:0] TYP_OFF = 16'd36924;
  localparam logic [COEF_W-1:0] TYP_TCS = 16'd23317;
  localparam logic [COEF_W-1:0] TYP_TCO = 16'd23282;
  localparam logic [COEF_W-1:0] TYP_TREF = 16'd33464;
  localparam logic [COEF_W-1:0] TYP_TSENS = 16'd28312;
  localparam logic [RAW_W-1:0] TYP_D1 = 24'd9085466;
  localparam logic [RAW_W-1:0] TYP_D2 = 24'd8569150;

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_we;
  logic [IDX_W-1:0] cfg_index;
  logic [COEF_W-1:0] cfg_wdata;

  int in_idle_pct;
  int out_stall_pct;
  int cal_loads;
  int cycles;
  logic [COEF_W-1:0] cur_tref;

  int pending;
  int err_count;
  int words_checked;
  int clip_count;

  int d2_sweep [10] = '{0, 6000000, 6800000, 7300000, 7600000, 8200000, 8566784, 8569150,
                        10500000, 16777215};
  int d1_sweep [3] = '{9085466, 16777215, 3000000};

  bpc_in_if in_ch ();
  bpc_out_if out_ch ();

  barometric_pressure_compensation_top u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  bpc_compensation_checker u_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata),
    .in_valid        (in_ch.valid),
    .in_ready        (in_ch.ready),
    .in_raw_pressure (in_ch.raw_pressure),
    .in_raw_temp     (in_ch.raw_temp),
    .out_valid       (out_ch.valid),
    .out_ready       (out_ch.ready),
    .out_temp_centi  (out_ch.temp_centi),
    .out_press_centi (out_ch.press_centi),
    .out_clipped     (out_ch.clipped),
    .pending         (pending),
    .err_count       (err_count),
    .words_checked   (words_checked),
    .clip_count      (clip_count)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb_barometric_pressure_compensation_top: FAIL");
      $finish;
    end
  end

  always @(negedge clk) begin
    out_ch.ready = ($urandom_range(0, 99) >= out_stall_pct);
  end

  task automatic write_coef(input logic [IDX_W-1:0] idx, input logic [COEF_W-1:0] val);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_wdata = val;
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  task automatic load_cal(input logic [COEF_W-1:0] s, input logic [COEF_W-1:0] o,
                          input logic [COEF_W-1:0] tcs, input logic [COEF_W-1:0] tco,
                          input logic [COEF_W-1:0] tref, input logic [COEF_W-1:0] tsens);
    while (pending != 0) @(negedge clk);
    write_coef(CFG_SENS, s);
    write_coef(CFG_OFF, o);
    write_coef(CFG_TCS, tcs);
    write_coef(CFG_TCO, tco);
    write_coef(CFG_TREF, tref);
    write_coef(CFG_TEMPSENS, tsens);
    write_coef(CFG_SPARE_LO, COEF_W'($urandom()));
    write_coef(CFG_SPARE_HI, COEF_W'($urandom()));
    cur_tref = tref;
    cal_loads++;
  endtask

  function automatic logic [COEF_W-1:0] jitter(input logic [COEF_W-1:0] base);
    return COEF_W'(base + $urandom_range(0, 4000) - 2000);
  endfunction

  task automatic send_word(input logic [RAW_W-1:0] p, input logic [RAW_W-1:0] t);
    while ($urandom_range(0, 99) < in_idle_pct) begin
      in_ch.valid = 1'b0;
      in_ch.raw_pressure = RAW_W'($urandom());
      in_ch.raw_temp = RAW_W'($urandom());
      @(negedge clk);
    end
    in_ch.valid = 1'b1;
    in_ch.raw_pressure = p;
    in_ch.raw_temp = t;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    @(negedge clk);
    in_ch.valid = 1'b0;
  endtask

  task automatic send_random_word();
    int sel;
    int offs;
    int d2;
    logic [RAW_W-1:0] p;
    logic [RAW_W-1:0] t;
    sel = $urandom_range(0, 9);
    if (sel < 7) begin
      // hold the temperature word near the reference so the correction branches fire
      offs = int'($urandom_range(0, 5000000)) - 2500000;
      d2 = int'(cur_tref) * 256 + offs;
      if (d2 < 0) d2 = 0;
      if (d2 > RAW_MAX) d2 = RAW_MAX;
      t = RAW_W'(d2);
      p = RAW_W'($urandom_range(2000000, 14000000));
    end else begin
      p = RAW_W'($urandom());
      t = RAW_W'($urandom());
    end
    send_word(p, t);
  endtask

  initial begin
    in_ch.valid = 1'b0;
    in_ch.raw_pressure = '0;
    in_ch.raw_temp = '0;
    out_ch.ready = 1'b0;
    cfg_we = 1'b0;
    cfg_index = CFG_SENS;
    cfg_wdata = '0;
    rst_n = 1'b0;
    in_idle_pct = 0;
    out_stall_pct = 0;
    cal_loads = 0;
    cur_tref = '0;
    repeat (5) @(negedge clk);
    rst_n = 1'b1;

    send_word('0, '0);
    send_word('1, '1);

    load_cal(TYP_SENS, TYP_OFF, TYP_TCS, TYP_TCO, TYP_TREF, TYP_TSENS);
    foreach (d2_sweep[i]) send_word(RAW_W'(d1_sweep[i % 3]), RAW_W'(d2_sweep[i]));
    send_word('1, '0);
    send_word('0, '1);

    load_cal('1, '1, '1, '1, '1, '1);
    send_word('0, '0);
    send_word('1, '1);
    send_word(TYP_D1, TYP_D2);

    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      in_idle_pct = 0;
      out_stall_pct = 0;
      case (phase)
        0, 4: begin
          load_cal(TYP_SENS, TYP_OFF, TYP_TCS, TYP_TCO, TYP_TREF, TYP_TSENS);
        end
        1: begin
          load_cal('1, '1, '1, '1, '1, '1);
        end
        2, 5: begin
          load_cal(jitter(TYP_SENS), jitter(TYP_OFF), jitter(TYP_TCS), jitter(TYP_TCO),
                   jitter(TYP_TREF), jitter(TYP_TSENS));
        end
        6: begin
          load_cal('0, '0, '0, '0, '0, '0);
        end
        default: begin
          load_cal(COEF_W'($urandom()), COEF_W'($urandom()), COEF_W'($urandom()),
                   COEF_W'($urandom()), COEF_W'($urandom()), COEF_W'($urandom()));
        end
      endcase
      case (phase % 4)
        1: begin
          in_idle_pct = 60;
        end
        2: begin
          out_stall_pct = 60;
        end
        3: begin
          in_idle_pct = 20;
          out_stall_pct = 20;
        end
        default: begin
        end
      endcase
      for (int n = 0; n < WORDS_PER_PHASE; n++) begin
        // hold off until the pipeline drains
        if (n == WORDS_PER_PHASE / 2) begin
          while (pending != 0) @(negedge clk);
        end
        send_random_word();
      end
    end

    in_idle_pct = 0;
    out_stall_pct = 0;
    while (pending != 0) @(negedge clk);
    repeat (20) @(negedge clk);

    $display("Checked %0d compensated readings under %0d calibration sets, %0d saturated.",
             words_checked, cal_loads, clip_count);
    if (err_count == 0) begin
      $display("tb_barometric_pressure_compensation_top: PASS");
    end else begin
      $display("tb_barometric_pressure_compensation_top: FAIL");
    end
    $finish;
  end

endmodule

// ===== barometric_pressure_compensation_top.f =====
rtl/core/bpc_pkg.sv
rtl/core/bpc_if.sv
rtl/core/bpc_front.sv
rtl/core/bpc_corr.sv
rtl/core/bpc_press.sv
rtl/core/barometric_pressure_compensation_top.sv
dv/bpc_compensation_checker.sv
dv/tb_barometric_pressure_compensation_top.sv
